[rtl/psob_pkg.sv]
// ----------------------------------------------------------------------------
// psob_pkg: shared types and helpers for the source-over blender
// Format codes, the pipeline control struct and the channel expansion helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psob_pkg;

	// destination format codes
	localparam logic [1:0] FMT_ARGB32 = 2'd0;
	localparam logic [1:0] FMT_RGB565 = 2'd1;
	localparam logic [1:0] FMT_RGB555 = 2'd2;

	localparam logic [7:0]  OPAQUE_ALPHA = 8'hFF;
	localparam logic [15:0] ROUND_BIAS   = 16'd127;
	// floor(x / 255) == (x * 32897) >> 23 for every 16-bit x
	localparam logic [31:0] DIV255_MUL   = 32'd32897;
	// floor(x / 31) and floor(x / 63) as reciprocal products, shift of 21
	localparam logic [29:0] EXP5_MUL     = 30'd67651;
	localparam logic [29:0] EXP6_MUL     = 30'd33289;

	// control that travels alongside each pixel
	typedef struct packed {
		logic       valid;
		logic       blend;
		logic [1:0] fmt;
	} ctrl_t;

	// widen a 5-bit channel to 8 bits as c * 255 / 31
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [12:0] x;
		logic [29:0] p;
		x = 13'(c) * 13'd255;
		p = 30'(x) * EXP5_MUL;
		return p[28:21];
	endfunction

	// widen a 6-bit channel to 8 bits as c * 255 / 63
	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [13:0] x;
		logic [29:0] p;
		x = 14'(c) * 14'd255;
		p = 30'(x) * EXP6_MUL;
		return p[28:21];
	endfunction

endpackage

[rtl/psob_mix.sv]
// ----------------------------------------------------------------------------
// psob_mix: one colour channel of the source-over blend
// Computes src + round(dst * inv / 255) modulo 256 over two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psob_mix import psob_pkg::*; (
	input  logic       clk,
	input  logic [7:0] src_s1,
	input  logic [7:0] dst_s1,
	input  logic [7:0] inv_s1,
	output logic [7:0] mix_s3
);

	logic [15:0] prod_s2;
	logic [7:0]  src_s2;
	logic [31:0] recip;
	logic [7:0]  quot_s3;
	logic [7:0]  src_s3;

	// scale the destination and add the rounding bias
	always_ff @(posedge clk) begin
		prod_s2 <= 16'(dst_s1) * 16'(inv_s1) + ROUND_BIAS;
		src_s2  <= src_s1;
	end

	// divide by 255 through a reciprocal product
	assign recip = 32'(prod_s2) * DIV255_MUL;

	always_ff @(posedge clk) begin
		quot_s3 <= recip[30:23];
		src_s3  <= src_s2;
	end

	// add the source, wrap at 8 bits
	assign mix_s3 = src_s3 + quot_s3;

endmodule

[rtl/premultiplied_source_over_blend.sv]
// ----------------------------------------------------------------------------
// premultiplied_source_over_blend: premultiplied source-over pixel blender
// A pixel taken at one edge passes the s1, s2 and s3 stages and the output registers before its result is on the ports.
// Throughput: one pixel per clock; busy stays low, the receiver cannot stall.
// Reset clears the valid bits of the pipeline and the format register (ARGB32).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module premultiplied_source_over_blend import psob_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	// pixel command
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  src_blue,
	input  logic [7:0]  src_green,
	input  logic [7:0]  src_red,
	input  logic [7:0]  src_alpha,
	input  logic [31:0] dst_pixel,
	// result
	output logic        done,
	output logic [31:0] out_pixel,
	output logic        written
);

	logic [1:0]  fmt_q;
	logic [7:0]  exp_b, exp_g, exp_r;
	logic        blend_in;
	ctrl_t       ctrl_s1, ctrl_s2, ctrl_s3;
	logic [7:0]  sb_s1, sg_s1, sr_s1, db_s1, dg_s1, dr_s1, inv_s1;
	logic [31:0] dst_s1, dst_s2, dst_s3;
	logic [7:0]  mb_s3, mg_s3, mr_s3;
	logic [31:0] packed_px;
	logic        done_q, written_q;
	logic [31:0] out_pixel_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// hold the format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_ARGB32;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	// unpack and widen the destination channels
	always_comb begin
		exp_b    = dst_pixel[7:0];
		exp_g    = dst_pixel[15:8];
		exp_r    = dst_pixel[23:16];
		blend_in = 1'b0;
		case (fmt_q)
			FMT_ARGB32: begin
				blend_in = (src_alpha != 8'd0);
			end
			FMT_RGB565: begin
				exp_b    = expand5(dst_pixel[4:0]);
				exp_g    = expand6(dst_pixel[10:5]);
				exp_r    = expand5(dst_pixel[15:11]);
				blend_in = (src_alpha != 8'd0);
			end
			FMT_RGB555: begin
				exp_b    = expand5(dst_pixel[4:0]);
				exp_g    = expand5(dst_pixel[9:5]);
				exp_r    = expand5(dst_pixel[14:10]);
				blend_in = (src_alpha != 8'd0);
			end
			default: begin
				blend_in = 1'b0;
			end
		endcase
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1 <= '{valid: start && !busy, blend: blend_in, fmt: fmt_q};
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		sb_s1  <= src_blue;
		sg_s1  <= src_green;
		sr_s1  <= src_red;
		db_s1  <= exp_b;
		dg_s1  <= exp_g;
		dr_s1  <= exp_r;
		inv_s1 <= ~src_alpha;
		dst_s1 <= dst_pixel;
		dst_s2 <= dst_s1;
		dst_s3 <= dst_s2;
	end

	psob_mix u_mix_b (.clk(clk), .src_s1(sb_s1), .dst_s1(db_s1), .inv_s1(inv_s1),
		.mix_s3(mb_s3));
	psob_mix u_mix_g (.clk(clk), .src_s1(sg_s1), .dst_s1(dg_s1), .inv_s1(inv_s1),
		.mix_s3(mg_s3));
	psob_mix u_mix_r (.clk(clk), .src_s1(sr_s1), .dst_s1(dr_s1), .inv_s1(inv_s1),
		.mix_s3(mr_s3));

	// repack in the destination format, or pass the destination through
	always_comb begin
		packed_px = dst_s3;
		if (ctrl_s3.blend) begin
			case (ctrl_s3.fmt)
				FMT_ARGB32: packed_px = {OPAQUE_ALPHA, mr_s3, mg_s3, mb_s3};
				FMT_RGB565: packed_px = {16'd0, mr_s3[7:3], mg_s3[7:2], mb_s3[7:3]};
				FMT_RGB555: packed_px = {16'd0, 1'b0, mr_s3[7:3], mg_s3[7:3], mb_s3[7:3]};
				default:    packed_px = dst_s3;
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		out_pixel_q <= packed_px;
		written_q   <= ctrl_s3.blend;
	end

	assign done      = done_q;
	assign out_pixel = out_pixel_q;
	assign written   = written_q && done_q;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted pixel did not produce a result beat");

	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !written) |-> (out_pixel == $past(dst_pixel, 4)))
		else $error("unwritten pixel differs from destination");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && written) |-> ($past(src_alpha, 4) != 8'd0))
		else $error("pixel written with zero alpha");

	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(done && written && fmt_q != FMT_ARGB32) |-> (out_pixel[31:16] == 16'd0))
		else $error("16-bit result has upper half set");
`endif

endmodule
